// ===== rtl/core/sds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_pkg
// Types and constants shared by the sprite depth sort block.
// ----------------------------------------------------------------------------
package sds_pkg;

	localparam int POS_W  = 24;
	localparam int KEY_W  = 27;
	localparam int TAG_W  = 16;
	localparam int MODE_W = 3;

	localparam logic [MODE_W-1:0] MODE_ISO      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ORTHO    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TOP_DOWN = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SIDE     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_EXPLICIT = 3'd4;

	// one held sprite
	typedef struct packed {
		logic                    valid;
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} cell_t;

	// sprite on its way into the chain
	typedef struct packed {
		logic                    valid;
		logic                    visible;
		logic                    last;
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} ins_t;

	// per-cycle command to every cell
	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

endpackage

// ===== rtl/core/sds_key.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_key
// Depth key stage: forms the twice-scale key for the render mode and
// registers the sprite for insertion.
// ----------------------------------------------------------------------------
module sds_key (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [sds_pkg::MODE_W-1:0]    depth_mode,
	input  logic [sds_pkg::POS_W-1:0]     pos_x,
	input  logic [sds_pkg::POS_W-1:0]     pos_y,
	input  logic [sds_pkg::POS_W-1:0]     pos_z,
	input  logic [sds_pkg::POS_W-1:0]     explicit_depth,
	input  logic                          visible,
	input  logic [sds_pkg::TAG_W-1:0]     sprite_tag,
	input  logic                          last,
	output sds_pkg::ins_t                 ins
);
	import sds_pkg::*;

	logic signed [KEY_W-1:0] x2;
	logic signed [KEY_W-1:0] y2;
	logic signed [KEY_W-1:0] z1;
	logic signed [KEY_W-1:0] z2;
	logic signed [KEY_W-1:0] d2;
	logic signed [KEY_W-1:0] key;
	logic                    valid_s1;
	logic                    visible_s1;
	logic                    last_s1;
	logic signed [KEY_W-1:0] key_s1;
	logic [TAG_W-1:0]        tag_s1;

	assign x2 = {{2{pos_x[POS_W-1]}}, pos_x, 1'b0};
	assign y2 = {{2{pos_y[POS_W-1]}}, pos_y, 1'b0};
	assign z2 = {{2{pos_z[POS_W-1]}}, pos_z, 1'b0};
	assign z1 = {{3{pos_z[POS_W-1]}}, pos_z};
	assign d2 = {{2{explicit_depth[POS_W-1]}}, explicit_depth, 1'b0};

	always_comb begin
		unique case (depth_mode)
			MODE_ISO:      key = x2 + y2 + z1;
			MODE_ORTHO:    key = y2;
			MODE_TOP_DOWN: key = z2;
			MODE_SIDE:     key = x2;
			default:       key = d2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			visible_s1 <= visible;
			last_s1    <= last;
			key_s1     <= key;
			tag_s1     <= sprite_tag;
		end
	end

	assign ins = '{valid: valid_s1, visible: visible_s1, last: last_s1,
		key: key_s1, tag: tag_s1};

endmodule

// ===== rtl/core/sds_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_cell
// One slot of the sorted chain: keeps its sprite, yields to a smaller new
// key by taking the new sprite or its left neighbor's, and shifts toward the head on readout.
// ----------------------------------------------------------------------------
module sds_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sds_pkg::cell_ctl_t  ctl,
	input  sds_pkg::cell_t      new_entry,
	input  sds_pkg::cell_t      prev_entry,
	input  sds_pkg::cell_t      next_entry,
	input  logic                prev_le,
	output sds_pkg::cell_t      entry,
	output logic                le
);
	import sds_pkg::*;

	logic                    valid_q;
	logic signed [KEY_W-1:0] key_q;
	logic [TAG_W-1:0]        tag_q;

	// held entry stays ahead of an equal or larger new key
	assign le = valid_q && (key_q <= new_entry.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= next_entry.valid;
		end else if (ctl.ins && !le) begin
			valid_q <= prev_le ? 1'b1 : prev_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= next_entry.key;
			tag_q <= next_entry.tag;
		end else if (ctl.ins && !le) begin
			if (prev_le) begin
				key_q <= new_entry.key;
				tag_q <= new_entry.tag;
			end else begin
				key_q <= prev_entry.key;
				tag_q <= prev_entry.tag;
			end
		end
	end

	assign entry = '{valid: valid_q, key: key_q, tag: tag_q};

endmodule

// ===== rtl/core/sprite_depth_sort_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_depth_sort_top
// Stable depth sort of a sprite set on a chain of insertion cells.
// ----------------------------------------------------------------------------
// While a set loads, one sprite word is taken every clock: the key stage
// registers the key, and the next cycle every cell of the CAPACITY-long chain
// compares against it at once and the sprite drops into place. After the word
// marked last, input is held off; once the last sprite has dropped into place
// the sorted list streams out of the head cell, one word per clock while the
// sink accepts (an empty set gives a single word). Visible sprites beyond
// CAPACITY are dropped and flagged on every output word of that set.
module sprite_depth_sort_top #(
	parameter int CAPACITY = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_wdata,   // depth_mode
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,     // pos_x, pos_y, pos_z, explicit_depth, sprite_tag
	input  logic [0:0]   s_tuser,     // visible
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,     // sorted_tag, depth_key, zero fill
	output logic [1:0]   m_tuser,     // empty_res, overflow
	output logic         m_tlast
);
	import sds_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_DRAIN = 3'b010,
		ST_EMPTY = 3'b100
	} state_t;

	state_t              state_q;
	logic [MODE_W-1:0]   mode_q;
	logic                ovf_q;
	ins_t                ins;
	cell_ctl_t           ctl;
	cell_t               new_entry;
	cell_t               cells [CAPACITY];
	logic [CAPACITY-1:0] cell_valid;
	logic [CAPACITY-1:0] le;
	logic                full;
	logic                s_acc;
	logic                m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ISO;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	sds_key u_key (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (s_acc),
		.depth_mode     (mode_q),
		.pos_x          (s_tdata[23:0]),
		.pos_y          (s_tdata[47:24]),
		.pos_z          (s_tdata[71:48]),
		.explicit_depth (s_tdata[95:72]),
		.visible        (s_tuser[0]),
		.sprite_tag     (s_tdata[111:96]),
		.last           (s_tlast),
		.ins            (ins)
	);

	assign full      = cell_valid[CAPACITY-1];
	assign new_entry = '{valid: 1'b1, key: ins.key, tag: ins.tag};
	assign ctl.ins   = (state_q == ST_LOAD) && ins.valid && ins.visible && !full;
	assign ctl.shift = (state_q == ST_DRAIN) && m_acc;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_t prev_entry;
		cell_t next_entry;
		logic  prev_le;

		if (i == 0) begin : g_head
			assign prev_entry = '0;
			assign prev_le    = 1'b1;
		end else begin : g_body
			assign prev_entry = cells[i-1];
			assign prev_le    = le[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_entry = '0;
		end else begin : g_link
			assign next_entry = cells[i+1];
		end

		sds_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.prev_le    (prev_le),
			.entry      (cells[i]),
			.le         (le[i])
		);

		assign cell_valid[i] = cells[i].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (ins.valid && ins.visible && full) begin
						ovf_q <= 1'b1;
					end
					if (ins.valid && ins.last) begin
						state_q <= (cell_valid[0] || ins.visible) ? ST_DRAIN : ST_EMPTY;
					end
				end
				ST_DRAIN: begin
					if (m_acc && !cell_valid[1]) begin
						state_q <= ST_LOAD;
						ovf_q   <= 1'b0;
					end
				end
				ST_EMPTY: begin
					if (m_acc) begin
						state_q <= ST_LOAD;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_LOAD) && !(ins.valid && ins.last);
	assign m_tvalid = (state_q == ST_DRAIN) || (state_q == ST_EMPTY);

	always_comb begin
		if (state_q == ST_DRAIN) begin
			m_tdata = {5'b0, cells[0].key, cells[0].tag};
			m_tuser = {ovf_q, 1'b0};
			m_tlast = !cell_valid[1];
		end else begin
			m_tdata = '0;
			m_tuser = {ovf_q, 1'b1};
			m_tlast = 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	// held sprites always sit packed at the head of the chain
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid >> 1) & ~cell_valid) == '0)
		else $error("gap in sort chain");

	// head is in order with its neighbor
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[1] |-> (cells[0].key <= cells[1].key))
		else $error("chain head out of order");

	// no input taken while results are shown
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready during readout");

	// empty result only with nothing held
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMPTY) |-> (cell_valid == '0))
		else $error("empty result with sprites held");

	// final word returns the block to loading with the chain cleared
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_acc && m_tlast) |=> ((state_q == ST_LOAD) && (cell_valid == '0) && !ovf_q))
		else $error("set not closed after final word");
`endif

endmodule

// ===== tb/sprite_depth_sort_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_depth_sort_top_tb
// Self-checking bench for the sprite depth sort block. Sprite sets are
// streamed in under every render mode, starting with extreme coordinates,
// equal keys, hidden sprites and an empty set, then random sets and ones that
// fill or overrun the chain. Both stream sides idle in random bursts and the
// sink stalls once for a long stretch so that input backs up. Every output
// word is compared against an in-bench insertion sort of the same sprites.
// ----------------------------------------------------------------------------
module sprite_depth_sort_top_tb;
	import sds_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int ITEM_TARGET = 370;
	localparam int CALM_AT     = 310;
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic [MODE_W-1:0] MODE_RSVD_FIRST = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD_MID   = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSVD_LAST  = 3'd7;

	typedef struct {
		logic [TAG_W-1:0]        tag;
		logic signed [KEY_W-1:0] key;
		logic                    empty_flag;
		logic                    ovf_flag;
		logic                    end_flag;
	} sorted_word_t;

	class depth_order_board;
		logic [MODE_W-1:0]       mode;
		logic signed [KEY_W-1:0] held_key[$];
		logic [TAG_W-1:0]        held_tag[$];
		bit                      dropped;
		sorted_word_t            pending[$];
		int                      errors;

		function new();
			mode    = MODE_ISO;
			dropped = 0;
			errors  = 0;
		endfunction

		function logic signed [KEY_W-1:0] depth_key_of(logic signed [POS_W-1:0] x,
				logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z,
				logic signed [POS_W-1:0] d);
			logic signed [KEY_W-1:0] xe, ye, ze, de;
			xe = x;
			ye = y;
			ze = z;
			de = d;
			case (mode)
				MODE_ISO:      return (xe <<< 1) + (ye <<< 1) + ze;
				MODE_ORTHO:    return ye <<< 1;
				MODE_TOP_DOWN: return ze <<< 1;
				MODE_SIDE:     return xe <<< 1;
				default:       return de <<< 1;
			endcase
		endfunction

		function void note_sprite(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
				logic signed [POS_W-1:0] z, logic signed [POS_W-1:0] d, logic vis,
				logic [TAG_W-1:0] tag, logic fin);
			logic signed [KEY_W-1:0] k;
			int                      pos;
			sorted_word_t            w;
			if (vis) begin
				if (held_key.size() < CAPACITY) begin
					k = depth_key_of(x, y, z, d);
					pos = 0;
					// equal keys keep arrival order
					while (pos < held_key.size() && held_key[pos] <= k)
						pos++;
					held_key.insert(pos, k);
					held_tag.insert(pos, tag);
				end else begin
					dropped = 1;
				end
			end
			if (fin) begin
				if (held_key.size() == 0) begin
					w.tag        = '0;
					w.key        = '0;
					w.empty_flag = 1'b1;
					w.ovf_flag   = dropped;
					w.end_flag   = 1'b1;
					pending.push_back(w);
				end else begin
					foreach (held_key[i]) begin
						w.tag        = held_tag[i];
						w.key        = held_key[i];
						w.empty_flag = 1'b0;
						w.ovf_flag   = dropped;
						w.end_flag   = (i == held_key.size() - 1);
						pending.push_back(w);
					end
				end
				held_key.delete();
				held_tag.delete();
				dropped = 0;
			end
		endfunction

		function void check_word(logic [TAG_W-1:0] tag, logic signed [KEY_W-1:0] key,
				logic empty_flag, logic ovf_flag, logic end_flag);
			sorted_word_t w;
			if (pending.size() == 0) begin
				$error("unexpected output word: sorted_tag %h depth_key %h", tag, key);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (tag !== w.tag) begin
				$error("sorted_tag: expected %h, actual %h", w.tag, tag);
				errors++;
			end
			if (key !== w.key) begin
				$error("depth_key: expected %0d, actual %0d", w.key, key);
				errors++;
			end
			if (empty_flag !== w.empty_flag) begin
				$error("empty_res: expected %b, actual %b", w.empty_flag, empty_flag);
				errors++;
			end
			if (ovf_flag !== w.ovf_flag) begin
				$error("overflow: expected %b, actual %b", w.ovf_flag, ovf_flag);
				errors++;
			end
			if (end_flag !== w.end_flag) begin
				$error("final_res: expected %b, actual %b", w.end_flag, end_flag);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [47:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	depth_order_board sb;
	int               sprites_sent;
	int               cycles;
	bit               calm;
	bit               gaps_on;
	bit               long_hold_req;

	sprite_depth_sort_top #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("sprite_depth_sort_top test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_sprite(s_tdata[23:0], s_tdata[47:24], s_tdata[71:48],
					s_tdata[95:72], s_tuser[0], s_tdata[111:96], s_tlast);
			if (m_tvalid && m_tready)
				sb.check_word(m_tdata[15:0], m_tdata[42:16], m_tuser[0], m_tuser[1],
					m_tlast);
		end
	end

	// sink side: random stall bursts, one long hold on request
	initial begin
		int stall;
		stall = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 0;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else if (!calm && gaps_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				stall = $urandom_range(0, 13);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [POS_W-1:0] pick_coord();
		int v;
		case ($urandom_range(0, 7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2, 3: begin
				v = $urandom_range(0, 8);
				return POS_W'(v - 4);
			end
			default: return POS_W'($urandom);
		endcase
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return TAG_W'($urandom);
		endcase
	endfunction

	task automatic send_sprite(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			input logic [POS_W-1:0] z, input logic [POS_W-1:0] d, input logic vis,
			input logic [TAG_W-1:0] tag, input logic fin);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {tag, d, z, y, x};
		s_tuser  <= vis;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sprites_sent++;
		if (sprites_sent >= CALM_AT)
			calm = 1;
	endtask

	task automatic sender_gap();
		if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 13))
				@(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	task automatic set_mode(input logic [MODE_W-1:0] m);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.mode = m;
	endtask

	task automatic run_set(input int n, input int vis_pct);
		for (int i = 0; i < n; i++) begin
			send_sprite(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
				$urandom_range(1, 100) <= vis_pct, pick_tag(), i == n - 1);
			sender_gap();
		end
	endtask

	initial begin
		logic [MODE_W-1:0] mode_plan[9];
		int                phase;
		int                set_no;
		mode_plan = '{MODE_ORTHO, MODE_TOP_DOWN, MODE_SIDE, MODE_RSVD_FIRST, MODE_ISO,
			MODE_RSVD_MID, MODE_EXPLICIT, MODE_RSVD_LAST, MODE_ISO};
		sb = new();
		sprites_sent  = 0;
		cycles        = 0;
		calm          = 0;
		gaps_on       = 1;
		long_hold_req = 0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		s_tlast   = 1'b0;
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// isometric extremes, equal keys, a hidden sprite in between
		set_mode(MODE_ISO);
		send_sprite(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h000000, 1'b1, 16'hFFFF, 1'b0);
		send_sprite(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 1'b1, 16'h0000, 1'b0);
		send_sprite(24'h000000, 24'h000000, 24'h000000, 24'h800000, 1'b1, 16'h0001, 1'b0);
		send_sprite(24'h000001, 24'hFFFFFF, 24'h000000, 24'h000000, 1'b1, 16'h0002, 1'b0);
		send_sprite(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b0, 16'h0003, 1'b0);
		send_sprite(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1, 16'h0004, 1'b1);
		// set with nothing visible
		send_sprite(24'h123456, 24'hABCDEF, 24'h5A5A5A, 24'hA5A5A5, 1'b0, 16'hBEEF, 1'b1);
		send_sprite(24'h7FFFFF, 24'h800000, 24'h000000, 24'h7FFFFF, 1'b0, 16'h1111, 1'b0);
		send_sprite(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h800000, 1'b1, 16'h2222, 1'b1);
		wait_drained();

		set_mode(MODE_EXPLICIT);
		send_sprite(pick_coord(), pick_coord(), pick_coord(), 24'h7FFFFF, 1'b1, 16'h00AA,
			1'b0);
		send_sprite(pick_coord(), pick_coord(), pick_coord(), 24'h800000, 1'b1, 16'h00BB,
			1'b0);
		send_sprite(pick_coord(), pick_coord(), pick_coord(), 24'h800000, 1'b1, 16'h00CC,
			1'b1);
		wait_drained();

		phase  = 0;
		set_no = 0;
		while (sprites_sent < ITEM_TARGET) begin
			set_mode(mode_plan[phase % 9]);
			if (phase == 1)
				run_set(CAPACITY + 6, 100);
			if (phase == 4)
				run_set(CAPACITY, 100);
			repeat (3) begin
				if (sprites_sent < ITEM_TARGET) begin
					set_no++;
					gaps_on = (set_no % 4 != 0);
					if (phase == 2 && set_no % 3 == 1) begin
						@(posedge clk);
						long_hold_req = 1;
					end
					run_set($urandom_range(1, 10), (set_no % 6 == 0) ? 15 : 85);
				end
			end
			wait_drained();
			phase++;
		end

		wait_drained();
		repeat (20)
			@(negedge clk);
		if (sb.errors == 0)
			$display("sprite_depth_sort_top test passed");
		else
			$display("sprite_depth_sort_top test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sds_pkg.sv
rtl/core/sds_key.sv
rtl/core/sds_cell.sv
rtl/core/sprite_depth_sort_top.sv
tb/sprite_depth_sort_top_tb.sv
